### hdl/srtf_pkg.sv
// Shared types and constants for the shortest-remaining-time-first scheduler.
package srtf_pkg;

    localparam int TIME_W = 16;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Candidate record handed down the cell chain during the minimum search.
    typedef struct packed {
        logic              valid;
        logic              started;
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] first;
    } t_rec;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic load;
        logic run;
        logic is_last;
    } t_cell_ctl;

endpackage

### hdl/srtf_cell.sv
// One process slot of the scheduler and its stage of the minimum-search chain.
module srtf_cell #(
    parameter int SLOTS = 8,
    parameter int IDX   = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  srtf_pkg::t_cell_ctl             i_ctl,
    input  logic [srtf_pkg::TIME_W-1:0]     i_time,
    input  logic [srtf_pkg::TIME_W-1:0]     i_burst,
    input  srtf_pkg::t_rec                  i_best,
    input  logic [$clog2(SLOTS)-1:0]        i_best_idx,
    output srtf_pkg::t_rec                  o_best,
    output logic [$clog2(SLOTS)-1:0]        o_best_idx,
    output logic                            o_active
);

    localparam int IW = $clog2(SLOTS);

    logic                          r_active;
    logic                          r_started;
    logic [srtf_pkg::TIME_W-1:0]   r_rem;
    logic [srtf_pkg::TIME_W-1:0]   r_burst;
    logic [srtf_pkg::TIME_W-1:0]   r_arr;
    logic [srtf_pkg::TIME_W-1:0]   r_first;
    srtf_pkg::t_rec                r_out;
    logic [IW-1:0]                 r_out_idx;
    srtf_pkg::t_rec                w_own;
    logic                          w_take;

    always_comb begin
        w_own.valid   = r_active;
        w_own.started = r_started;
        w_own.rem     = r_rem;
        w_own.burst   = r_burst;
        w_own.arr     = r_arr;
        w_own.first   = r_first;
    end

    // Strictly smaller wins, so the lower slot keeps a tie unless this slot ran last.
    assign w_take = r_active && (!i_best.valid || (r_rem < i_best.rem) ||
                                 ((r_rem == i_best.rem) && i_ctl.is_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_started <= 1'b0;
            r_out     <= '0;
            r_out_idx <= '0;
        end else begin
            r_out     <= w_take ? w_own : i_best;
            r_out_idx <= w_take ? IW'(IDX) : i_best_idx;
            if (i_ctl.load) begin
                r_active  <= 1'b1;
                r_started <= 1'b0;
            end else if (i_ctl.run) begin
                if (r_rem == srtf_pkg::TIME_W'(1)) begin
                    r_active  <= 1'b0;
                    r_started <= 1'b0;
                end else begin
                    r_started <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem   <= i_burst;
            r_burst <= i_burst;
            r_arr   <= i_time;
        end else if (i_ctl.run) begin
            r_rem <= r_rem - srtf_pkg::TIME_W'(1);
            if (!r_started) begin
                r_first <= i_time;
            end
        end
    end

    assign o_best     = r_out;
    assign o_best_idx = r_out_idx;
    assign o_active   = r_active;

endmodule

### hdl/srtf_scheduler_top.sv
// Top level of the shortest-remaining-time-first scheduler: sequencer and slot chain.
//
//  Channel   Handshake           Payload
//  input     i_valid / o_ready   i_mode, i_process_id, i_burst_time
//  output    o_valid / i_ready   o_ran_valid, o_ran_process, o_finished, o_turnaround_time,
//                                o_waiting_time, o_response_time, o_arrival_error
//
// An arrival request goes from idle straight to the done state; a tick first passes through the search state, since
// the least remaining time ripples through the chain one cell per cycle.
// One request is in flight at a time; the result register lets the next request be
// accepted while the previous result waits. A full result register holds the commit.
// Reset is synchronous and active low; it clears time, slot occupancy and last runner.
module srtf_scheduler_top #(
    parameter int SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [2:0]  i_process_id,
    input  logic [15:0] i_burst_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ran_valid,
    output logic [2:0]  o_ran_process,
    output logic        o_finished,
    output logic [15:0] o_turnaround_time,
    output logic [15:0] o_waiting_time,
    output logic [15:0] o_response_time,
    output logic        o_arrival_error
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TW = srtf_pkg::TIME_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    logic [1:0]     r_state;
    logic [CW-1:0]  r_cnt;
    logic           r_mode;
    logic [2:0]     r_pid;
    logic [TW-1:0]  r_burst;
    logic [TW-1:0]  r_time;
    logic [IW-1:0]  r_lr;
    logic           r_lr_valid;

    logic           r_o_valid;
    logic           r_o_ran_valid;
    logic [2:0]     r_o_ran_process;
    logic           r_o_finished;
    logic [TW-1:0]  r_o_tat;
    logic [TW-1:0]  r_o_wt;
    logic [TW-1:0]  r_o_rt;
    logic           r_o_err;

    srtf_pkg::t_rec      w_chain [SLOTS+1];
    logic [IW-1:0]       w_idx   [SLOTS+1];
    srtf_pkg::t_cell_ctl w_ctl   [SLOTS];
    logic [SLOTS-1:0]    w_active;
    logic [SLOTS-1:0]    w_hit;

    logic           w_commit;
    logic           w_err;
    logic           w_run;
    srtf_pkg::t_rec w_best;
    logic [IW-1:0]  w_bidx;
    logic [TW-1:0]  w_t_next;
    logic [TW-1:0]  w_first;
    logic           w_fin;
    logic [TW-1:0]  w_tat;
    logic [TW-1:0]  w_wt;
    logic [TW-1:0]  w_rt;

    assign w_chain[0] = '0;
    assign w_idx[0]   = '0;

    assign w_commit = (r_state == ST_DONE) && (!r_o_valid || i_ready);
    assign w_err    = (r_burst == '0) || !(|w_hit) || (|(w_hit & w_active));
    assign w_best   = w_chain[SLOTS];
    assign w_bidx   = w_idx[SLOTS];
    assign w_run    = w_commit && r_mode && w_best.valid;

    genvar k;
    generate
        for (k = 0; k < SLOTS; k++) begin : g_cell
            assign w_hit[k]          = (32'(r_pid) == k);
            assign w_ctl[k].load     = w_commit && !r_mode && !w_err && w_hit[k];
            assign w_ctl[k].run      = w_run && (w_bidx == IW'(k));
            assign w_ctl[k].is_last  = r_lr_valid && (r_lr == IW'(k));

            srtf_cell #(
                .SLOTS (SLOTS),
                .IDX   (k)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl[k]),
                .i_time     (r_time),
                .i_burst    (r_burst),
                .i_best     (w_chain[k]),
                .i_best_idx (w_idx[k]),
                .o_best     (w_chain[k+1]),
                .o_best_idx (w_idx[k+1]),
                .o_active   (w_active[k])
            );
        end
    endgenerate

    // Completion figures of the chosen slot, with time advanced past this tick.
    assign w_t_next = (r_time == srtf_pkg::TIME_MAX) ? r_time : r_time + TW'(1);
    assign w_first  = w_best.started ? w_best.first : r_time;
    assign w_fin    = (w_best.rem == TW'(1));
    assign w_tat    = w_t_next - w_best.arr;
    assign w_wt     = (w_tat >= w_best.burst) ? (w_tat - w_best.burst) : '0;
    assign w_rt     = w_first - w_best.arr;

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_time     <= '0;
            r_lr       <= '0;
            r_lr_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_cnt   <= '0;
                        r_state <= i_mode ? ST_SEARCH : ST_DONE;
                    end
                end
                ST_SEARCH: begin
                    // The chain end is settled once every cell has been passed.
                    if (r_cnt == CW'(SLOTS - 1)) begin
                        r_state <= ST_DONE;
                    end
                    r_cnt <= r_cnt + CW'(1);
                end
                ST_DONE: begin
                    if (w_commit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (w_commit && r_mode) begin
                r_time <= w_t_next;
            end
            if (w_run) begin
                r_lr       <= w_bidx;
                r_lr_valid <= !w_fin;
            end

            if (w_commit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mode  <= i_mode;
            r_pid   <= i_process_id;
            r_burst <= i_burst_time;
        end
        if (w_commit) begin
            r_o_ran_valid   <= w_run;
            r_o_ran_process <= w_run ? 3'(w_bidx) : 3'd0;
            r_o_finished    <= w_run && w_fin;
            r_o_tat         <= (w_run && w_fin) ? w_tat : '0;
            r_o_wt          <= (w_run && w_fin) ? w_wt : '0;
            r_o_rt          <= (w_run && w_fin) ? w_rt : '0;
            r_o_err         <= !r_mode && w_err;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_ran_valid       = r_o_ran_valid;
    assign o_ran_process     = r_o_ran_process;
    assign o_finished        = r_o_finished;
    assign o_turnaround_time = r_o_tat;
    assign o_waiting_time    = r_o_wt;
    assign o_response_time   = r_o_rt;
    assign o_arrival_error   = r_o_err;

endmodule
